// ===== hw/rtl/bfws_pkg.sv =====
// shared types, codes and controller/datapath command and status bundles
package bfws_pkg;

  localparam int MODE_BITS   = 2;
  localparam int STATUS_BITS = 2;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_READ = 2'd2,
    MODE_FIND = 2'd3
  } mode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // read address source
  typedef enum logic [1:0] {
    RD_HEAD,
    RD_POS,
    RD_NEXT
  } rd_sel_t;

  // kind of result to form
  typedef enum logic [2:0] {
    RES_PUSH_OK,
    RES_FULL,
    RES_EMPTY,
    RES_MISS,
    RES_POP,
    RES_READ,
    RES_HIT
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     scan_step;
    logic     res_load;
    res_sel_t res_sel;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  empty;
    logic  pos_ok;
    logic  hit;
    logic  last;
    logic  out_free;
  } sts_t;

endpackage

// ===== hw/rtl/bfws_if.sv =====
// item and result channel interfaces
interface bfws_in_if #(
  parameter int DEPTH     = 16,
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32
);
  localparam int POS_BITS = $clog2(DEPTH);

  logic                           valid;
  logic                           ready;
  logic [bfws_pkg::MODE_BITS-1:0] mode;
  logic [KEY_BITS-1:0]            entry_key;
  logic [DATA_BITS-1:0]           entry_data;
  logic [POS_BITS-1:0]            position;

  modport source (output valid, mode, entry_key, entry_data, position, input ready);
  modport sink   (input valid, mode, entry_key, entry_data, position, output ready);
endinterface

interface bfws_out_if #(
  parameter int DEPTH     = 16,
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32
);
  localparam int POS_BITS   = $clog2(DEPTH);
  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  logic                             valid;
  logic                             ready;
  logic [bfws_pkg::STATUS_BITS-1:0] status;
  logic [KEY_BITS-1:0]              out_key;
  logic [DATA_BITS-1:0]             out_data;
  logic [POS_BITS-1:0]              found_position;
  logic [COUNT_BITS-1:0]            count;

  modport source (output valid, status, out_key, out_data, found_position, count,
                  input ready);
  modport sink   (input valid, status, out_key, out_data, found_position, count,
                  output ready);
endinterface

// ===== hw/rtl/bfws_ctrl.sv =====
// sequencing state machine for the search fifo
module bfws_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bfws_pkg::sts_t sts,
  output bfws_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.rd_sel  = bfws_pkg::RD_HEAD;
    cmd.res_sel = bfws_pkg::RES_MISS;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.mode)
          bfws_pkg::MODE_PUSH: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = sts.full ? bfws_pkg::RES_FULL : bfws_pkg::RES_PUSH_OK;
            state_nxt    = S_EMIT;
          end
          bfws_pkg::MODE_POP: begin
            if (sts.empty) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = bfws_pkg::RES_EMPTY;
              state_nxt    = S_EMIT;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = bfws_pkg::RD_HEAD;
              state_nxt  = S_WAIT;
            end
          end
          bfws_pkg::MODE_READ: begin
            if (sts.pos_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = bfws_pkg::RD_POS;
              state_nxt  = S_WAIT;
            end else begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = bfws_pkg::RES_MISS;
              state_nxt    = S_EMIT;
            end
          end
          bfws_pkg::MODE_FIND: begin
            if (sts.empty) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = bfws_pkg::RES_MISS;
              state_nxt    = S_EMIT;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = bfws_pkg::RD_HEAD;
              state_nxt  = S_SCAN;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_WAIT: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = (sts.mode == bfws_pkg::MODE_POP) ? bfws_pkg::RES_POP
                                                         : bfws_pkg::RES_READ;
        state_nxt    = S_EMIT;
      end
      S_SCAN: begin
        // compare the entry just read while fetching the one after it
        if (sts.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = bfws_pkg::RES_HIT;
          state_nxt    = S_EMIT;
        end else if (sts.last) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = bfws_pkg::RES_MISS;
          state_nxt    = S_EMIT;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = bfws_pkg::RD_NEXT;
          cmd.scan_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/bfws_datapath.sv =====
// entry stores, pointers, scan index and result/output registers
module bfws_datapath #(
  parameter int DEPTH     = 16,
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bfws_pkg::cmd_t                   cmd,
  output bfws_pkg::sts_t                   sts,
  input  logic [bfws_pkg::MODE_BITS-1:0]   in_mode,
  input  logic [KEY_BITS-1:0]              in_key,
  input  logic [DATA_BITS-1:0]             in_data,
  input  logic [$clog2(DEPTH)-1:0]         in_pos,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bfws_pkg::STATUS_BITS-1:0] out_status,
  output logic [KEY_BITS-1:0]              out_key,
  output logic [DATA_BITS-1:0]             out_data,
  output logic [$clog2(DEPTH)-1:0]         out_fpos,
  output logic [$clog2(DEPTH+1)-1:0]       out_count
);

  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int COUNT_BITS = $clog2(DEPTH + 1);
  localparam int OFF_BITS   = ADDR_BITS + 1;
  localparam logic [OFF_BITS-1:0]   DEPTH_OFF = OFF_BITS'(DEPTH);
  localparam logic [COUNT_BITS-1:0] DEPTH_CNT = COUNT_BITS'(DEPTH);

  // slot of an offset from a base, modulo DEPTH; base + off stays below 2*DEPTH
  function automatic logic [ADDR_BITS-1:0] slot_of(input logic [ADDR_BITS-1:0] base,
                                                   input logic [OFF_BITS-1:0]  off);
    logic [OFF_BITS-1:0] sum;
    sum = {1'b0, base} + off;
    if (sum >= DEPTH_OFF) begin
      sum = sum - DEPTH_OFF;
    end
    return sum[ADDR_BITS-1:0];
  endfunction

  logic [KEY_BITS-1:0]  key_mem  [DEPTH];
  logic [DATA_BITS-1:0] data_mem [DEPTH];

  bfws_pkg::mode_t        mode_r;
  logic [KEY_BITS-1:0]    key_r;
  logic [DATA_BITS-1:0]   data_r;
  logic [ADDR_BITS-1:0]   pos_r;
  logic [ADDR_BITS-1:0]   head_r;
  logic [COUNT_BITS-1:0]  cnt_r;
  logic [ADDR_BITS-1:0]   idx_r;
  logic [KEY_BITS-1:0]    rd_key_r;
  logic [DATA_BITS-1:0]   rd_data_r;

  bfws_pkg::status_t      res_status_r, res_status_nxt;
  logic [KEY_BITS-1:0]    res_key_r, res_key_nxt;
  logic [DATA_BITS-1:0]   res_data_r, res_data_nxt;
  logic [ADDR_BITS-1:0]   res_fpos_r, res_fpos_nxt;

  logic                   out_valid_r;
  logic [bfws_pkg::STATUS_BITS-1:0] out_status_r;
  logic [KEY_BITS-1:0]    out_key_r;
  logic [DATA_BITS-1:0]   out_data_r;
  logic [ADDR_BITS-1:0]   out_fpos_r;
  logic [COUNT_BITS-1:0]  out_count_r;

  logic [OFF_BITS-1:0]    rd_off;
  logic [ADDR_BITS-1:0]   rd_addr;
  logic [ADDR_BITS-1:0]   wr_addr;
  logic [ADDR_BITS-1:0]   head_plus1;
  logic                   wr_en;

  always_comb begin
    case (cmd.rd_sel)
      bfws_pkg::RD_POS:  rd_off = {1'b0, pos_r};
      bfws_pkg::RD_NEXT: rd_off = {1'b0, idx_r} + OFF_BITS'(1);
      default:           rd_off = '0;
    endcase
  end

  assign rd_addr    = slot_of(head_r, rd_off);
  assign wr_addr    = slot_of(head_r, OFF_BITS'(cnt_r));
  assign head_plus1 = slot_of(head_r, OFF_BITS'(1));
  assign wr_en      = cmd.res_load && (cmd.res_sel == bfws_pkg::RES_PUSH_OK);

  assign sts.mode     = mode_r;
  assign sts.full     = (cnt_r == DEPTH_CNT);
  assign sts.empty    = (cnt_r == '0);
  assign sts.pos_ok   = (COUNT_BITS'(pos_r) < cnt_r);
  assign sts.hit      = (rd_key_r == key_r);
  assign sts.last     = ((COUNT_BITS'(idx_r) + COUNT_BITS'(1)) == cnt_r);
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= key_r;
      data_mem[wr_addr] <= data_r;
    end
    if (cmd.rd_en) begin
      rd_key_r  <= key_mem[rd_addr];
      rd_data_r <= data_mem[rd_addr];
    end
  end

  always_comb begin
    res_status_nxt = bfws_pkg::ST_OK;
    res_key_nxt    = '0;
    res_data_nxt   = '0;
    res_fpos_nxt   = '0;
    case (cmd.res_sel)
      bfws_pkg::RES_FULL:  res_status_nxt = bfws_pkg::ST_FULL;
      bfws_pkg::RES_EMPTY: res_status_nxt = bfws_pkg::ST_EMPTY;
      bfws_pkg::RES_MISS:  res_status_nxt = bfws_pkg::ST_MISS;
      bfws_pkg::RES_POP, bfws_pkg::RES_READ: begin
        res_key_nxt  = rd_key_r;
        res_data_nxt = rd_data_r;
      end
      bfws_pkg::RES_HIT: begin
        res_key_nxt  = rd_key_r;
        res_data_nxt = rd_data_r;
        res_fpos_nxt = idx_r;
      end
      default: res_status_nxt = bfws_pkg::ST_OK;
    endcase
  end

  // pointers and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.res_load) begin
        case (cmd.res_sel)
          bfws_pkg::RES_PUSH_OK: cnt_r <= cnt_r + COUNT_BITS'(1);
          bfws_pkg::RES_POP: begin
            cnt_r  <= cnt_r - COUNT_BITS'(1);
            // last entry gone: restart at slot zero
            head_r <= (cnt_r == COUNT_BITS'(1)) ? '0 : head_plus1;
          end
          default: ;
        endcase
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= bfws_pkg::mode_t'(in_mode);
      key_r  <= in_key;
      data_r <= in_data;
      pos_r  <= in_pos;
      idx_r  <= '0;
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + ADDR_BITS'(1);
    end
    if (cmd.res_load) begin
      res_status_r <= res_status_nxt;
      res_key_r    <= res_key_nxt;
      res_data_r   <= res_data_nxt;
      res_fpos_r   <= res_fpos_nxt;
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_key_r    <= res_key_r;
      out_data_r   <= res_data_r;
      out_fpos_r   <= res_fpos_r;
      out_count_r  <= cnt_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_key    = out_key_r;
  assign out_data   = out_data_r;
  assign out_fpos   = out_fpos_r;
  assign out_count  = out_count_r;

endmodule

// ===== hw/rtl/bounded_fifo_with_search_core.sv =====
// Bounded queue of DEPTH key/data entries with push, pop, read-at-position and
// find-by-key. Every item gives one result beat carrying a status and the entry
// count after the item. Items are handled one at a time; the result sits in an
// output register, so the next item is taken while a result waits. A push, or
// any item rejected for full, empty or out-of-range, is resolved without reading
// the store; a pop or a read in range first reads the entry store; a find reads
// entries from the head until the first match or the last entry. The find time
// is set by the single read port of the entry store, which the scan walks one
// entry per cycle from the head. The store needs no clearing after reset.
module bounded_fifo_with_search_core #(
  parameter int DEPTH     = 16,
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32
) (
  input logic      clk,
  input logic      rst_n,
  bfws_in_if.sink  in_if,
  bfws_out_if.source out_if
);

  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  bfws_pkg::cmd_t cmd;
  bfws_pkg::sts_t sts;

  bfws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfws_datapath #(
    .DEPTH     (DEPTH),
    .KEY_BITS  (KEY_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (in_if.mode),
    .in_key     (in_if.entry_key),
    .in_data    (in_if.entry_data),
    .in_pos     (in_if.position),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_status (out_if.status),
    .out_key    (out_if.out_key),
    .out_data   (out_if.out_data),
    .out_fpos   (out_if.found_position),
    .out_count  (out_if.count)
  );

  // one item at a time: no second beat straight after an accepted one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input taken while an item is in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.count <= COUNT_BITS'(DEPTH)))
    else $error("entry count above depth");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.status == bfws_pkg::ST_EMPTY)) |-> (out_if.count == '0))
    else $error("empty status with entries held");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.status == bfws_pkg::ST_FULL))
      |-> (out_if.count == COUNT_BITS'(DEPTH)))
    else $error("full status with room left");

endmodule
